FILE: rtl/core/bbas_pkg.sv
package bbas_pkg;

  // Parser phase within a line
  typedef enum logic [1:0] {
    PH_EXPECT = 2'd0,
    PH_RUN    = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  // Status codes reported with each result
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_START  = 3'd1,
    ST_MISMATCH   = 3'd2,
    ST_TOO_DEEP   = 3'd3,
    ST_UNFINISHED = 3'd4
  } status_t;

  // Expected-closer codes held on the stack
  typedef logic [1:0] code_t;
  localparam code_t CODE_PAREN   = 2'd0;
  localparam code_t CODE_BRACE   = 2'd1;
  localparam code_t CODE_BRACKET = 2'd2;
  localparam code_t CODE_ANGLE   = 2'd3;

  // Delimiter bytes
  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_RPAREN   = 8'h29;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_LANGLE   = 8'h3C;
  localparam logic [7:0] CH_RANGLE   = 8'h3E;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_COMMA    = 8'h2C;

  // Stack control handed from the parser to the cell row
  typedef struct packed {
    logic  push;
    logic  pop;
    code_t code;
  } stack_ctl_t;

  // One result beat
  typedef struct packed {
    logic [7:0] out_char;
    logic       char_kept;
    logic       arg_end;
    logic       list_closed;
    logic       line_done;
    status_t    status;
  } res_t;

  function automatic logic is_closer(logic [7:0] c);
    return (c == CH_RPAREN) || (c == CH_RBRACE) || (c == CH_RBRACKET) || (c == CH_RANGLE);
  endfunction

  function automatic code_t closer_of(logic [7:0] c);
    code_t r;
    r = CODE_PAREN;
    case (c)
      CH_RBRACE:   r = CODE_BRACE;
      CH_RBRACKET: r = CODE_BRACKET;
      CH_RANGLE:   r = CODE_ANGLE;
      default:     r = CODE_PAREN;
    endcase
    return r;
  endfunction

  function automatic logic is_opener(logic [7:0] c);
    return (c == CH_LPAREN) || (c == CH_LBRACE) || (c == CH_LBRACKET) || (c == CH_LANGLE);
  endfunction

  function automatic code_t opener_of(logic [7:0] c);
    code_t r;
    r = CODE_PAREN;
    case (c)
      CH_LBRACE:   r = CODE_BRACE;
      CH_LBRACKET: r = CODE_BRACKET;
      CH_LANGLE:   r = CODE_ANGLE;
      default:     r = CODE_PAREN;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/bbas_if.sv
// Input channel: one text byte per beat
interface bbas_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       line_last;

  modport source (output valid, output in_char, output line_last, input ready);
  modport sink   (input valid, input in_char, input line_last, output ready);
endinterface

// Output channel: one classified byte per beat
interface bbas_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_kept;
  logic       arg_end;
  logic       list_closed;
  logic       line_done;
  logic [2:0] status;

  modport source (output valid, output out_char, output char_kept, output arg_end,
                  output list_closed, output line_done, output status, input ready);
  modport sink   (input valid, input out_char, input char_kept, input arg_end,
                  input list_closed, input line_done, input status, output ready);
endinterface

FILE: rtl/core/bbas_cell.sv
// One stack slot: shifts toward the bottom on push, toward the top on pop
module bbas_cell
  import bbas_pkg::*;
(
  input  logic       clk,
  input  stack_ctl_t ctl,
  input  code_t      above,
  input  code_t      below,
  output code_t      code
);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      code <= above;
    end else if (ctl.pop) begin
      code <= below;
    end
  end

endmodule

FILE: rtl/core/bbas_stack.sv
// Row of closer cells; cell 0 is the top of the stack
module bbas_stack
  import bbas_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic       clk,
  input  stack_ctl_t ctl,
  output code_t      top
);

  code_t slot [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    code_t above;
    code_t below;

    // neighbor wiring; the ends take the new code and their own value
    if (i == 0) begin : g_head
      assign above = ctl.code;
    end else begin : g_mid_a
      assign above = slot[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_tail
      assign below = slot[i];
    end else begin : g_mid_b
      assign below = slot[i+1];
    end

    bbas_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .above (above),
      .below (below),
      .code  (slot[i])
    );
  end

  assign top = slot[0];

endmodule

FILE: rtl/core/bracket_balanced_argument_splitter.sv
// Channel | Dir | Beat contents
// din     | in  | in_char, line_last
// dout    | out | out_char, char_kept, arg_end, list_closed, line_done, status
//
// One byte per cycle while the output queue has room, one result per byte; each result is
// registered in the output queue before it reaches dout. The rate is set by the stack top compare
// and the single push or pop of the cell row, both done in the cycle a byte is taken.
// Results go through a two-beat output queue; din is taken whenever it has room.
// rst clears phase, quote, depth, error and the queue; stack cells are not reset.
module bracket_balanced_argument_splitter
  import bbas_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  bbas_in_if.sink       din,
  bbas_out_if.source    dout
);

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam logic [DW-1:0] DEPTH_MAX = DW'(STACK_DEPTH);

  // Parser state
  phase_t        phase, phase_next;
  logic          in_quote, in_quote_next;
  logic [DW-1:0] nest_depth, nest_depth_next;
  logic [1:0]    line_error, line_error_next;

  // Output queue
  res_t       q [2];
  logic       wp, rp;
  logic [1:0] cnt;

  logic       fire, deq;
  logic [7:0] c;
  logic       last;
  code_t      top;
  stack_ctl_t sctl;

  logic    kept, aend, closed, run_stays;
  status_t err, status;

  assign c    = din.in_char;
  assign last = din.line_last;
  assign din.ready = (cnt != 2'd2);
  assign fire = din.valid && din.ready;
  assign deq  = dout.valid && dout.ready;

  bbas_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
    .clk (clk),
    .ctl (sctl),
    .top (top)
  );

  // Byte classification and per-byte outputs
  always_comb begin
    err    = ST_OK;
    kept   = 1'b0;
    aend   = 1'b0;
    closed = 1'b0;
    sctl   = '{push: 1'b0, pop: 1'b0, code: opener_of(c)};
    unique case (phase)
      PH_EXPECT: begin
        if (c != CH_LPAREN) err = ST_BAD_START;
      end
      PH_RUN: begin
        if (in_quote) begin
          kept = 1'b1;
        end else if (is_closer(c)) begin
          if (nest_depth == '0) begin
            if (closer_of(c) == CODE_PAREN) begin
              closed = 1'b1;
              aend   = 1'b1;
            end else begin
              err = ST_MISMATCH;
            end
          end else if (top == closer_of(c)) begin
            sctl.pop = fire;
            kept     = 1'b1;
          end else begin
            err = ST_MISMATCH;
          end
        end else if (is_opener(c)) begin
          if (nest_depth == DEPTH_MAX) begin
            err = ST_TOO_DEEP;
          end else begin
            sctl.push = fire;
            kept      = 1'b1;
          end
        end else if (c == CH_COMMA && nest_depth == '0) begin
          aend = 1'b1;
        end else begin
          kept = 1'b1;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    run_stays = (err == ST_OK) && !closed && (phase == PH_EXPECT || phase == PH_RUN);

    if (err != ST_OK) status = err;
    else if (phase == PH_DONE) status = status_t'({1'b0, line_error});
    else status = ST_OK;

    // line ends while the list is still open
    if (last && run_stays) begin
      aend   = 1'b1;
      status = ST_UNFINISHED;
    end
  end

  // Next state
  always_comb begin
    phase_next      = phase;
    in_quote_next   = in_quote;
    nest_depth_next = nest_depth;
    line_error_next = line_error;
    if (fire) begin
      unique case (phase)
        PH_EXPECT: begin
          phase_next      = (err == ST_OK) ? PH_RUN : PH_DONE;
          in_quote_next   = 1'b0;
          nest_depth_next = '0;
        end
        PH_RUN: begin
          if (err != ST_OK || closed) phase_next = PH_DONE;
          if (in_quote) begin
            if (c == CH_QUOTE) in_quote_next = 1'b0;
          end else if (!is_closer(c) && !is_opener(c) && c == CH_QUOTE) begin
            in_quote_next = 1'b1;
          end
          if (sctl.push) nest_depth_next = nest_depth + 1'b1;
          else if (sctl.pop) nest_depth_next = nest_depth - 1'b1;
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase
      if (err != ST_OK) line_error_next = err[1:0];
      if (last) begin
        phase_next      = PH_EXPECT;
        in_quote_next   = 1'b0;
        nest_depth_next = '0;
        line_error_next = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_EXPECT;
      in_quote   <= 1'b0;
      nest_depth <= '0;
      line_error <= 2'd0;
    end else begin
      phase      <= phase_next;
      in_quote   <= in_quote_next;
      nest_depth <= nest_depth_next;
      line_error <= line_error_next;
    end
  end

  // Two-beat output queue
  always_ff @(posedge clk) begin
    if (fire) begin
      q[wp] <= '{out_char: c, char_kept: kept, arg_end: aend, list_closed: closed,
                 line_done: last, status: status};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (fire) wp <= ~wp;
      if (deq)  rp <= ~rp;
      cnt <= cnt + {1'b0, fire} - {1'b0, deq};
    end
  end

  assign dout.valid       = (cnt != 2'd0);
  assign dout.out_char    = q[rp].out_char;
  assign dout.char_kept   = q[rp].char_kept;
  assign dout.arg_end     = q[rp].arg_end;
  assign dout.list_closed = q[rp].list_closed;
  assign dout.line_done   = q[rp].line_done;
  assign dout.status      = q[rp].status;

endmodule

FILE: rtl/core/bbas_checker.sv
module bbas_checker
  import bbas_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       char_kept,
  input logic       arg_end,
  input logic       list_closed,
  input logic       line_done,
  input logic [2:0] status
);

  // a stalled result beat holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({out_char, char_kept, arg_end,
                                                      list_closed, line_done, status}))
    else $error("result changed while stalled");

  // the balancing closer ends the last argument, cleanly
  a_close: assert property (@(posedge clk) disable iff (rst)
    out_valid && list_closed |-> arg_end && !char_kept && status == ST_OK)
    else $error("list close without argument end");

  // an error byte is dropped and ends nothing
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_BAD_START || status == ST_MISMATCH || status == ST_TOO_DEEP)
    |-> !char_kept && !arg_end && !list_closed)
    else $error("error beat kept or ended an argument");

  // unfinished only on the last byte of a line, which ends the argument
  a_unf: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_UNFINISHED |-> line_done && arg_end && !list_closed)
    else $error("unfinished status off line end");

endmodule

bind bracket_balanced_argument_splitter bbas_checker u_bbas_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (dout.valid),
  .out_ready   (dout.ready),
  .out_char    (dout.out_char),
  .char_kept   (dout.char_kept),
  .arg_end     (dout.arg_end),
  .list_closed (dout.list_closed),
  .line_done   (dout.line_done),
  .status      (dout.status)
);

FILE: tb/split_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the splitter, predicts each result beat from the
// accepted input beats and compares them in order.
module split_checker
  import bbas_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  bbas_in_if   din,
  bbas_out_if  dout,
  output int   fail_count,
  output int   pending
);

  // Predicted parser state
  phase_t      ph;
  logic        quoted;
  int unsigned depth;
  code_t       closers[STACK_DEPTH];
  status_t     held_err;

  res_t expected_q[$];

  // Closer code of a byte; bit 2 set when the byte closes nothing
  function automatic logic [2:0] closer_kind(logic [7:0] c);
    case (c)
      CH_RPAREN:   return {1'b0, CODE_PAREN};
      CH_RBRACE:   return {1'b0, CODE_BRACE};
      CH_RBRACKET: return {1'b0, CODE_BRACKET};
      CH_RANGLE:   return {1'b0, CODE_ANGLE};
      default:     return 3'b100;
    endcase
  endfunction

  // Closer code that an opening byte pushes; bit 2 set when it opens nothing
  function automatic logic [2:0] opener_kind(logic [7:0] c);
    case (c)
      CH_LPAREN:   return {1'b0, CODE_PAREN};
      CH_LBRACE:   return {1'b0, CODE_BRACE};
      CH_LBRACKET: return {1'b0, CODE_BRACKET};
      CH_LANGLE:   return {1'b0, CODE_ANGLE};
      default:     return 3'b100;
    endcase
  endfunction

  // Classify one byte and advance the predicted state
  function automatic res_t classify_byte(logic [7:0] c, logic last);
    res_t       r;
    status_t    err;
    logic [2:0] ck;
    logic [2:0] ok;
    r             = '0;
    r.out_char    = c;
    r.line_done   = last;
    r.status      = ST_OK;
    err           = ST_OK;
    ck            = closer_kind(c);
    ok            = opener_kind(c);
    case (ph)
      PH_EXPECT: begin
        if (c == CH_LPAREN) begin
          ph     = PH_RUN;
          quoted = 1'b0;
          depth  = 0;
        end else begin
          err = ST_BAD_START;
        end
      end
      PH_RUN: begin
        if (quoted) begin
          r.char_kept = 1'b1;
          if (c == CH_QUOTE) quoted = 1'b0;
        end else if (!ck[2]) begin
          // a closer at top level must be the one for the opening paren
          if (depth == 0) begin
            if (ck[1:0] == CODE_PAREN) begin
              r.list_closed = 1'b1;
              r.arg_end     = 1'b1;
              ph            = PH_DONE;
            end else begin
              err = ST_MISMATCH;
            end
          end else if (closers[depth-1] == ck[1:0]) begin
            depth       = depth - 1;
            r.char_kept = 1'b1;
          end else begin
            err = ST_MISMATCH;
          end
        end else if (!ok[2]) begin
          if (depth >= STACK_DEPTH) begin
            err = ST_TOO_DEEP;
          end else begin
            closers[depth] = ok[1:0];
            depth          = depth + 1;
            r.char_kept    = 1'b1;
          end
        end else if (c == CH_QUOTE) begin
          quoted      = 1'b1;
          r.char_kept = 1'b1;
        end else if (c == CH_COMMA && depth == 0) begin
          r.arg_end = 1'b1;
        end else begin
          r.char_kept = 1'b1;
        end
      end
      default: begin
        r.status = held_err;
      end
    endcase

    // errors drop the byte and latch for the rest of the line
    if (err != ST_OK) begin
      held_err    = err;
      ph          = PH_DONE;
      r.status    = err;
      r.char_kept = 1'b0;
      r.arg_end   = 1'b0;
    end

    // end of line: close an open list as unfinished, then start over
    if (last) begin
      if (ph == PH_RUN) begin
        r.arg_end = 1'b1;
        r.status  = ST_UNFINISHED;
      end
      ph       = PH_EXPECT;
      quoted   = 1'b0;
      depth    = 0;
      held_err = ST_OK;
    end
    return r;
  endfunction

  task check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Predict on input beats, compare on output beats
  always @(posedge clk) begin : watch
    res_t want;
    if (rst) begin
      ph       = PH_EXPECT;
      quoted   = 1'b0;
      depth    = 0;
      held_err = ST_OK;
      expected_q.delete();
    end else begin
      if (din.valid && din.ready)
        expected_q.insert(expected_q.size(), classify_byte(din.in_char, din.line_last));
      if (dout.valid && dout.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat, char %0d status %0d", $time,
                   dout.out_char, dout.status);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("out_char", want.out_char, dout.out_char);
          check_field("char_kept", want.char_kept, dout.char_kept);
          check_field("arg_end", want.arg_end, dout.arg_end);
          check_field("list_closed", want.list_closed, dout.list_closed);
          check_field("line_done", want.line_done, dout.line_done);
          check_field("status", want.status, dout.status);
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb
  import bbas_pkg::*;
();

  localparam int STACK_DEPTH = 16;
  localparam int TOTAL_ITEMS = 1225;
  localparam int CALM_FROM   = 1075;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bbas_in_if  din ();
  bbas_out_if dout ();

  int fail_count;
  int pending;

  int         sent = 0;
  logic       calm = 1'b0;
  logic [7:0] line_q[$];
  logic [7:0] shut_q[$];

  bracket_balanced_argument_splitter #(
    .STACK_DEPTH(STACK_DEPTH)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .din (din),
    .dout(dout)
  );

  split_checker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) split_check (
    .clk       (clk),
    .rst       (rst),
    .din       (din),
    .dout      (dout),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // One byte beat, with an occasional burst of idle cycles in front
  task send_byte(input logic [7:0] c, input logic last);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      din.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    din.valid     <= 1'b1;
    din.in_char   <= c;
    din.line_last <= last;
    @(posedge clk);
    while (!din.ready) @(posedge clk);
    sent++;
    if (sent >= CALM_FROM) calm = 1'b1;
    @(negedge clk);
  endtask

  task send_line();
    int i;
    for (i = 0; i < line_q.size(); i++) send_byte(line_q[i], i == line_q.size() - 1);
    line_q.delete();
  endtask

  // Append a byte to the line being built
  task line_add(input logic [7:0] b);
    line_q.insert(line_q.size(), b);
  endtask

  // Remember a closer still owed by the line
  task shut_add(input logic [7:0] b);
    shut_q.insert(shut_q.size(), b);
  endtask

  task add_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) line_add(s[i]);
  endtask

  // Random opener, remembering the closer that balances it
  task add_opener();
    case ($urandom_range(0, 3))
      0: begin line_add(CH_LPAREN);   shut_add(CH_RPAREN);   end
      1: begin line_add(CH_LBRACE);   shut_add(CH_RBRACE);   end
      2: begin line_add(CH_LBRACKET); shut_add(CH_RBRACKET); end
      default: begin line_add(CH_LANGLE); shut_add(CH_RANGLE); end
    endcase
  endtask

  task close_all();
    while (shut_q.size() != 0) line_add(shut_q.pop_back());
    line_add(CH_RPAREN);
  endtask

  // Mostly well-formed lists with random content; some deep, broken or noise
  task build_line();
    int         kind;
    int         n;
    int         i;
    int         j;
    int         pick;
    logic [7:0] b;
    kind = $urandom_range(0, 99);
    shut_q.delete();
    if (kind < 10) begin
      n = $urandom_range(1, 10);
      for (i = 0; i < n; i++) line_add(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 1) line_q[0] = CH_LPAREN;
    end else if (kind < 20) begin
      // nesting near and past the stack size
      line_add(CH_LPAREN);
      n = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 2);
      for (i = 0; i < n; i++) add_opener();
      close_all();
    end else begin
      line_add(CH_LPAREN);
      n = $urandom_range(1, 24);
      for (i = 0; i < n; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 15 && shut_q.size() < 4) begin
          add_opener();
        end else if (pick < 35 && shut_q.size() != 0) begin
          line_add(shut_q.pop_back());
        end else if (pick < 50) begin
          line_add(CH_COMMA);
        end else if (pick < 60) begin
          line_add(CH_QUOTE);
          for (j = $urandom_range(0, 5); j > 0; j--) begin
            b = 8'($urandom_range(0, 255));
            line_add(b == CH_QUOTE ? 8'h71 : b);
          end
          line_add(CH_QUOTE);
        end else begin
          line_add(8'($urandom_range(8'h61, 8'h7A)));
        end
      end
      if ($urandom_range(0, 7) != 0) begin
        close_all();
        for (j = $urandom_range(0, 3); j > 0; j--)
          line_add(8'($urandom_range(0, 255)));
      end
      // corrupt one byte
      if (kind < 32) line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
    end
  endtask

  // Output side: random stall bursts until the quiet tail of the run
  initial begin : sink_side
    int run;
    dout.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        run = $urandom_range(1, 8);
        dout.ready <= 1'b0;
        repeat (run) @(negedge clk);
      end
      run = $urandom_range(1, 12);
      dout.ready <= 1'b1;
      repeat (run) @(negedge clk);
    end
  end

  initial begin
    din.valid     = 1'b0;
    din.in_char   = 8'h00;
    din.line_last = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // closed list followed by a dropped byte
    add_text("(),");
    send_line();
    // bad start on extreme bytes, error repeats
    line_add(8'h00);
    line_add(8'hFF);
    send_line();
    // quoted delimiters, every bracket kind, top-level comma on the last byte
    add_text("(\",)\"[<{}>],");
    send_line();
    // wrong closer at top level, then a byte under the latched error
    add_text("(]x");
    send_line();
    // wrong closer inside nesting on the last byte
    add_text("([)");
    send_line();
    // line ends right after the opening paren
    add_text("(");
    send_line();

    while (sent < TOTAL_ITEMS) begin
      build_line();
      send_line();
    end
    din.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: bracket_balanced_argument_splitter.f
rtl/core/bbas_pkg.sv
rtl/core/bbas_if.sv
rtl/core/bbas_cell.sv
rtl/core/bbas_stack.sv
rtl/core/bracket_balanced_argument_splitter.sv
rtl/core/bbas_checker.sv
tb/split_checker.sv
tb/tb.sv
